// File: hdl/sjs_pkg.sv
// Shared constants, codes and controller/datapath interface types for the jump search store.
package sjs_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned STRIDE_W    = 6;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned DATA_W      = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic read;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic done;
  } status_t;

endpackage

// File: hdl/sjs_ctrl.sv
// Controller state machine: word handshakes and sequencing of the search walk.
module sjs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       func_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  sjs_pkg::status_t status_i,
  output sjs_pkg::cmd_t    cmd_o
);
  import sjs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_CLEAR:  cmd_o.clear  = 1'b1;
            FUNC_APPEND: cmd_o.append = 1'b1;
            FUNC_QUERY: begin
              cmd_o.start = 1'b1;
              state_d     = status_i.empty ? ST_RESULT : ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = status_i.done ? ST_RESULT : ST_READ;
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/sjs_dpath.sv
// Datapath: value store, count and stride tracking, walk position and result register.
module sjs_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sjs_pkg::cmd_t                       cmd_i,
  output sjs_pkg::status_t                    status_o,
  input  logic signed [sjs_pkg::DATA_W-1:0]   value_i,
  output logic                                found_o,
  output logic [sjs_pkg::CNT_W-1:0]           visited_o
);
  import sjs_pkg::*;

  logic signed [DATA_W-1:0] mem [MAX_ENTRIES];

  logic [CNT_W-1:0]         count_q;
  logic [STRIDE_W-1:0]      stride_q;
  logic [CNT_W-1:0]         sq_q;
  logic [CNT_W-1:0]         pos_q;
  logic [STRIDE_W-1:0]      phase_q;
  logic [CNT_W-1:0]         seen_q;
  logic                     hit_q;
  logic signed [DATA_W-1:0] target_q;
  logic signed [DATA_W-1:0] rd_a_q;
  logic signed [DATA_W-1:0] rd_b_q;
  logic                     found_q;
  logic [CNT_W-1:0]         visited_q;

  logic [CNT_W-1:0]    count_inc;
  logic [CNT_W:0]      jump_sum;
  logic [CNT_W-1:0]    pos_inc;
  logic [STRIDE_W-1:0] phase_inc;
  logic                is_full;
  logic                eq;
  logic                jump;

  assign count_inc = count_q + CNT_W'(1);
  assign is_full   = (count_q == CNT_W'(MAX_ENTRIES));
  assign jump_sum  = {1'b0, pos_q} + (CNT_W + 1)'(stride_q);
  assign pos_inc   = pos_q + CNT_W'(1);
  assign phase_inc = phase_q + STRIDE_W'(1);
  assign eq        = (rd_a_q == target_q);
  assign jump      = (stride_q != '0) && (phase_q == '0) &&
                     (jump_sum < {1'b0, count_q}) && (rd_b_q <= target_q);

  assign status_o.empty = (count_q == '0);
  assign status_o.done  = eq || (!jump && (pos_inc >= count_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      stride_q <= '0;
      sq_q     <= '0;
    end else if (cmd_i.clear) begin
      count_q  <= '0;
      stride_q <= '0;
      sq_q     <= '0;
    end else if (cmd_i.append && !is_full) begin
      count_q <= count_inc;
      if (count_inc > sq_q) begin
        stride_q <= stride_q + STRIDE_W'(1);
        sq_q     <= sq_q + CNT_W'({stride_q, 1'b1});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !is_full) begin
      mem[count_q[IDX_W-1:0]] <= value_i;
    end
    if (cmd_i.read) begin
      rd_a_q <= mem[pos_q[IDX_W-1:0]];
      rd_b_q <= mem[jump_sum[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      target_q <= value_i;
      pos_q    <= '0;
      phase_q  <= '0;
      seen_q   <= '0;
      hit_q    <= 1'b0;
    end else if (cmd_i.step) begin
      seen_q <= seen_q + CNT_W'(1);
      if (eq) begin
        hit_q <= 1'b1;
      end else if (jump) begin
        pos_q <= jump_sum[CNT_W-1:0];
      end else begin
        pos_q   <= pos_inc;
        phase_q <= (phase_inc == stride_q) ? '0 : phase_inc;
      end
    end
    if (cmd_i.load_out) begin
      found_q   <= hit_q;
      visited_q <= seen_q;
    end
  end

  assign found_o   = found_q;
  assign visited_o = visited_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_square_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_q == CNT_W'(stride_q * stride_q))
    else $error("stride square out of step with stride");

  a_stride_ceil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_q >= count_q) && ((stride_q == '0) == (count_q == '0)))
    else $error("stride is not the ceiling square root of the count");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (phase_q < stride_q) && (pos_q < count_q))
    else $error("walk position or block phase out of range");

endmodule

// File: hdl/sqrt_jump_search_store.sv
// Top level of the jump search store: controller plus datapath.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+----------------------------
//  input   | in_valid_i  | in_stall_o   | func_i[1:0], value_i[31:0]
//  output  | out_valid_o | out_stall_i  | found_o, visited_o[10:0]
//
//  Clear and append words are acted on in ST_IDLE; func 3 is dropped there.
//  A query walks the store per visited element: a registered store read
//  (ST_READ), then compare and step (ST_CMP); it ends in ST_RESULT.
//  Each store read fetches the walk position and its jump target together.
//  Reset (rst_ni low) empties the store; no clearing pass is needed.
//  A finished result waits in the output register under out_stall_i while
//  the next input word is taken; a query ending then waits to load it.
module sqrt_jump_search_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sjs_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [sjs_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              found_o,
  output logic [sjs_pkg::CNT_W-1:0]         visited_o
);
  import sjs_pkg::*;

  cmd_t    cmd;
  status_t status;

  sjs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sjs_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .value_i   (value_i),
    .found_o   (found_o),
    .visited_o (visited_o)
  );

endmodule

// File: tb/tb_sqrt_jump_search_store.sv
// Self-checking testbench for the jump search store: random words, shadow model, result check.
module tb_sqrt_jump_search_store;
  import sjs_pkg::*;

  localparam logic [FUNC_W-1:0]        FuncUnused = 2'd3;
  localparam logic signed [DATA_W-1:0] ValMin     = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ValMax     = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int unsigned              MaxGap     = 16;
  localparam int unsigned              RandWords  = 580;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
  } word_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] visited;
  } reply_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [FUNC_W-1:0]        func_i      = '0;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     found_o;
  logic [CNT_W-1:0]         visited_o;

  sqrt_jump_search_store i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .visited_o   (visited_o)
  );

  // pending words and expected results
  word_t  word_q[$];
  reply_t reply_q[$];

  // shadow store
  logic signed [DATA_W-1:0] mem [MAX_ENTRIES];
  int unsigned              mem_cnt    = 0;
  int unsigned              mem_stride = 0;

  // generator view of the store, used to aim queries and size the time limit
  logic signed [DATA_W-1:0] gen_vals[$];
  longint unsigned          gen_budget = 0;
  int unsigned              n_words    = 0;

  int unsigned     err_cnt   = 0;
  longint unsigned cyc       = 0;
  longint unsigned run_limit = 0;
  int unsigned     in_gap    = 0;
  int unsigned     out_hold  = 0;
  bit              in_burst  = 1'b0;
  bit              out_burst = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch %s: expected %0d got %0d", what, want, got);
    err_cnt++;
  endtask

  task automatic apply_word(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v);
    int unsigned pos;
    int unsigned seen;
    int unsigned k;
    reply_t      r;
    case (f)
      FUNC_CLEAR: begin
        mem_cnt    = 0;
        mem_stride = 0;
      end
      FUNC_APPEND: begin
        if (mem_cnt < MAX_ENTRIES) begin
          mem[mem_cnt] = v;
          mem_cnt++;
          k = 0;
          while (k * k < mem_cnt) k++;
          mem_stride = k;
        end
      end
      FUNC_QUERY: begin
        pos     = 0;
        seen    = 0;
        r.found = 1'b0;
        while (pos < mem_cnt) begin
          seen++;
          if (mem[pos] == v) begin
            r.found = 1'b1;
            break;
          end
          if (mem_stride != 0 && pos % mem_stride == 0 && pos + mem_stride < mem_cnt &&
              mem[pos + mem_stride] <= v)
            pos += mem_stride;
          else
            pos++;
        end
        r.visited = seen[CNT_W-1:0];
        reply_q.insert(reply_q.size(), r);
      end
      default: ;
    endcase
  endtask

  task automatic add_word(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v);
    word_t w;
    w.func  = f;
    w.value = v;
    word_q.insert(word_q.size(), w);
    gen_budget += 2 * MaxGap + 8;
    case (f)
      FUNC_CLEAR: begin
        gen_vals.delete();
        n_words++;
      end
      FUNC_APPEND: begin
        if (gen_vals.size() < MAX_ENTRIES) begin
          gen_vals.insert(gen_vals.size(), v);
          n_words++;
        end
      end
      FUNC_QUERY: begin
        gen_budget += 2 * gen_vals.size() + 2;
        n_words++;
      end
      default: ;
    endcase
  endtask

  // ascending run; narrow runs give many duplicates
  task automatic append_sorted(input int unsigned n, input bit narrow);
    longint      cur;
    int unsigned span;
    span = narrow ? 3 : 32'hFFFF_FFFF / (n + 1);
    if (narrow)
      cur = longint'($urandom_range(0, 200)) - 100;
    else
      cur = -64'sd2147483648 + longint'($urandom_range(1, span));
    repeat (n) begin
      add_word(FUNC_APPEND, cur[DATA_W-1:0]);
      cur += longint'($urandom_range(0, span));
      if (cur > 64'sd2147483647) cur = 64'sd2147483647;
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_target();
    int unsigned              r;
    logic signed [DATA_W-1:0] v;
    r = $urandom_range(0, 9);
    if (gen_vals.size() == 0 || r >= 8) return $urandom();
    v = gen_vals[$urandom_range(0, gen_vals.size() - 1)];
    if (r < 5) return v;
    if (r == 5) return v + 1;
    if (r == 6) return v - 1;
    return $urandom_range(0, 1) ? ValMin : ValMax;
  endfunction

  // stimulus and end of run
  initial begin : stim_p
    int unsigned r;
    // directed
    add_word(FUNC_QUERY, 0);
    add_word(FuncUnused, ValMax);
    add_word(FUNC_APPEND, ValMin);
    add_word(FUNC_APPEND, -1);
    add_word(FUNC_APPEND, 0);
    add_word(FUNC_APPEND, 1);
    add_word(FUNC_APPEND, ValMax);
    add_word(FUNC_QUERY, ValMin);
    add_word(FUNC_QUERY, ValMax);
    add_word(FUNC_QUERY, 0);
    add_word(FUNC_QUERY, 1);
    add_word(FUNC_QUERY, 2);
    add_word(FUNC_QUERY, ValMin + 1);
    add_word(FUNC_QUERY, -1);
    add_word(FuncUnused, 0);
    add_word(FUNC_QUERY, 1);
    add_word(FUNC_CLEAR, 0);
    add_word(FUNC_QUERY, 1);
    add_word(FUNC_APPEND, 50);
    add_word(FUNC_APPEND, 10);
    add_word(FUNC_APPEND, 30);
    add_word(FUNC_APPEND, 20);
    add_word(FUNC_QUERY, 20);
    add_word(FUNC_QUERY, 10);
    add_word(FUNC_QUERY, 40);
    // full store, appends past the end are dropped
    add_word(FUNC_CLEAR, ValMax);
    append_sorted(MAX_ENTRIES + 6, 1'b0);
    add_word(FUNC_QUERY, ValMin);
    add_word(FUNC_QUERY, ValMax);
    add_word(FUNC_QUERY, gen_vals[0]);
    add_word(FUNC_QUERY, gen_vals[MAX_ENTRIES - 1]);
    repeat (4) add_word(FUNC_QUERY, pick_target());
    // random
    n_words = 0;
    while (n_words < RandWords) begin
      r = $urandom_range(0, 9);
      if (r <= 5) begin
        add_word(FUNC_CLEAR, $urandom());
        append_sorted(($urandom_range(0, 7) == 0) ? $urandom_range(41, 200)
                                                  : $urandom_range(1, 40),
                      $urandom_range(0, 1));
        repeat ($urandom_range(1, 8)) add_word(FUNC_QUERY, pick_target());
      end else if (r == 6) begin
        repeat ($urandom_range(1, 4)) add_word(FUNC_APPEND, $urandom());
        add_word(FUNC_QUERY, pick_target());
      end else if (r == 7) begin
        repeat ($urandom_range(1, 3)) add_word(FuncUnused, $urandom());
        add_word(FUNC_QUERY, $urandom());
      end else if (r == 8) begin
        repeat ($urandom_range(1, 4)) add_word(FUNC_QUERY, pick_target());
      end else begin
        add_word(FUNC_CLEAR, $urandom());
        add_word(FUNC_QUERY, pick_target());
      end
    end
    run_limit = 4 * gen_budget + 8 * MAX_ENTRIES + 1000;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (word_q.size() != 0 || in_valid_i || reply_q.size() != 0) @(posedge clk_i);
    repeat (2 * MAX_ENTRIES + 8) @(posedge clk_i);
    if (err_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // input driver
  always @(posedge clk_i) begin : drv_p
    bit          took;
    bit          load_next;
    int unsigned gap_n;
    took      = 1'b0;
    load_next = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        took = 1'b1;
        apply_word(func_i, value_i);
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        gap_n = in_burst ? 0 : $urandom_range(0, MaxGap);
        if (gap_n == 0) load_next = 1'b1;
        else in_gap <= gap_n;
      end else if (!in_valid_i) begin
        if (in_gap != 0) in_gap <= in_gap - 1;
        else load_next = 1'b1;
      end
      if (load_next && word_q.size() != 0) begin
        func_i     <= word_q[0].func;
        value_i    <= word_q[0].value;
        in_valid_i <= 1'b1;
        void'(word_q.pop_front());
      end else if (took) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : mon_p
    reply_t      want;
    int unsigned hold_n;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch("unexpected result, visited", 0, visited_o);
        end else begin
          want = reply_q.pop_front();
          if (found_o !== want.found) report_mismatch("found", want.found, found_o);
          if (visited_o !== want.visited) report_mismatch("visited", want.visited, visited_o);
        end
        if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
        hold_n = out_burst ? 0 : $urandom_range(0, MaxGap);
        out_hold    <= hold_n;
        out_stall_i <= (hold_n != 0);
      end else if (out_hold != 0) begin
        out_hold    <= out_hold - 1;
        out_stall_i <= (out_hold > 1);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > run_limit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
